// ===== rtl/tvic_pkg.sv =====
// Package with types, constants and the priority search for the triple interrupt controller.
`default_nettype none

package tvic_pkg;

   localparam int NUM_CONTROLLERS = 3;
   localparam int VECTOR_WIDTH    = 16;
   localparam int LINES           = 8;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_RAISE = 2'd2,
      OP_ACK   = 2'd3
   } tvic_op_type;

   typedef enum logic [1:0] {
      WSEL_MASK = 2'd0,
      WSEL_ACLR = 2'd1,
      WSEL_VEC  = 2'd2,
      WSEL_NONE = 2'd3
   } tvic_wsel_type;

   localparam logic [1:0] RSEL_ISR  = 2'd0;
   localparam logic [1:0] RSEL_MASK = 2'd1;
   localparam logic [1:0] RSEL_REQ  = 2'd2;
   localparam logic [1:0] RSEL_ACLR = 2'd3;

   localparam int MODE_ROT_BIT    = 0;
   localparam int MODE_COMMON_BIT = 1;
   localparam int MODE_POLLED_BIT = 2;
   localparam int MODE_MASTER_BIT = 7;

   localparam logic [7:0] ALL_ONES        = 8'o377;
   localparam logic [7:0] STATUS_NONE     = 8'o200;
   localparam logic [7:0] MODE_KEEP_HIGH  = 8'o340;
   localparam logic [7:0] MODE_LOW_FIELD  = 8'o037;
   localparam logic [7:0] MODE_KEEP_RSEL  = 8'o237;
   localparam logic [7:0] MODE_RSEL_FIELD = 8'o140;

   localparam logic [1:0] MASTER_ON  = 2'd1;
   localparam logic [1:0] MASTER_OFF = 2'd2;

   // Command codes are bits 7:3 of the command byte.
   localparam logic [4:0] CMD_CLR_REQ_MASK     = 5'd2;
   localparam logic [4:0] CMD_CLR_REQ_MASK_BIT = 5'd3;
   localparam logic [4:0] CMD_CLR_MASK         = 5'd4;
   localparam logic [4:0] CMD_CLR_MASK_BIT     = 5'd5;
   localparam logic [4:0] CMD_SET_MASK         = 5'd6;
   localparam logic [4:0] CMD_SET_MASK_BIT     = 5'd7;
   localparam logic [4:0] CMD_CLR_REQ          = 5'd8;
   localparam logic [4:0] CMD_CLR_REQ_BIT      = 5'd9;
   localparam logic [4:0] CMD_SET_REQ          = 5'd10;
   localparam logic [4:0] CMD_SET_REQ_BIT      = 5'd11;
   localparam logic [4:0] CMD_CLR_ISR          = 5'd14;
   localparam logic [4:0] CMD_CLR_ISR_BIT      = 5'd15;
   localparam logic [4:0] CMD_MODE0_A          = 5'd16;
   localparam logic [4:0] CMD_MODE0_B          = 5'd17;
   localparam logic [4:0] CMD_MODE0_C          = 5'd18;
   localparam logic [4:0] CMD_MODE0_D          = 5'd19;
   localparam logic [4:0] CMD_MODE1_A          = 5'd20;
   localparam logic [4:0] CMD_MODE1_B          = 5'd21;
   localparam logic [4:0] CMD_PSEL_MASK_A      = 5'd22;
   localparam logic [4:0] CMD_PSEL_MASK_B      = 5'd23;
   localparam logic [4:0] CMD_PSEL_ACLR_A      = 5'd24;
   localparam logic [4:0] CMD_PSEL_ACLR_B      = 5'd25;
   localparam logic [4:0] CMD_PSEL_VEC         = 5'd28;

   typedef struct packed {
      logic        wr_en;
      logic        set_en;
      logic        ack_en;
      logic        port;
      logic [15:0] data;
      logic [7:0]  rq;
   } tvic_cmd_type;

   typedef struct packed {
      logic        qual;
      logic        qual_next;
      logic [7:0]  rd_data;
      logic [15:0] vector;
   } tvic_stat_type;

   typedef struct packed {
      logic       found;
      logic [2:0] line;
   } tvic_pend_type;

   function automatic tvic_pend_type find_pending(input logic [7:0] live,
                                                  input logic [2:0] start);
      tvic_pend_type r;
      logic [2:0]    l;
      r = '0;
      for (int k = LINES - 1; k >= 0; k--) begin
         l = start + 3'(k);
         if (live[l]) begin
            r.found = 1'b1;
            r.line  = l;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tvic_req_if.sv =====
// Request channel interface: bus accesses, request-line sets and acknowledges.
`default_nettype none

interface tvic_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [1:0]  controller;
   logic        port_select;
   logic [15:0] write_data;
   logic [7:0]  request_mask;

   modport source (output valid, op, controller, port_select, write_data, request_mask,
                   input ready);
   modport sink (input valid, op, controller, port_select, write_data, request_mask,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/tvic_rsp_if.sv =====
// Response channel interface: read data, vector, no-interrupt flag and group line.
`default_nettype none

interface tvic_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic [15:0] vector;
   logic        no_interrupt;
   logic        int_line;

   modport source (output valid, read_data, vector, no_interrupt, int_line, input ready);
   modport sink (input valid, read_data, vector, no_interrupt, int_line, output ready);
endinterface

`default_nettype wire

// ===== rtl/tvic_ctrl.sv =====
// One eight-line interrupt controller: registers, command decode and priority search.
`default_nettype none

module tvic_ctrl
   import tvic_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  tvic_cmd_type  cmd,
   output tvic_stat_type stat
);

   logic [7:0]              req_ff, req_in;
   logic [7:0]              isr_ff, isr_in;
   logic [7:0]              mask_ff, mask_in;
   logic [7:0]              aclr_ff, aclr_in;
   logic [7:0]              mode_ff, mode_in;
   logic [2:0]              rot_ff, rot_in;
   tvic_wsel_type           wsel_ff, wsel_in;
   logic [2:0]              vsel_ff, vsel_in;
   logic [VECTOR_WIDTH-1:0] vec_ff [LINES];
   logic [VECTOR_WIDTH-1:0] vec_in [LINES];

   tvic_pend_type pend, pend_next;
   logic [7:0]    bit_sel;
   logic [7:0]    ack_bit;
   logic [7:0]    status;

   always_comb begin
      pend    = find_pending(req_ff & ~mask_ff, mode_ff[MODE_ROT_BIT] ? rot_ff : 3'd0);
      bit_sel = 8'b1 << cmd.data[2:0];
      ack_bit = 8'b1 << pend.line;

      req_in  = req_ff;
      isr_in  = isr_ff;
      mask_in = mask_ff;
      aclr_in = aclr_ff;
      mode_in = mode_ff;
      rot_in  = rot_ff;
      wsel_in = wsel_ff;
      vsel_in = vsel_ff;
      vec_in  = vec_ff;

      if (cmd.wr_en) begin
         if (cmd.port) begin
            if (cmd.data[7:0] == 8'd0) begin
               req_in  = '0;
               isr_in  = '0;
               mask_in = ALL_ONES;
               aclr_in = '0;
               mode_in = '0;
               wsel_in = WSEL_MASK;
            end else begin
               unique case (cmd.data[7:3]) inside
                  CMD_CLR_REQ_MASK: begin
                     req_in  = '0;
                     mask_in = '0;
                  end
                  CMD_CLR_REQ_MASK_BIT: begin
                     req_in  = req_ff & ~bit_sel;
                     mask_in = mask_ff & ~bit_sel;
                  end
                  CMD_CLR_MASK:     mask_in = '0;
                  CMD_CLR_MASK_BIT: mask_in = mask_ff & ~bit_sel;
                  CMD_SET_MASK:     mask_in = ALL_ONES;
                  CMD_SET_MASK_BIT: mask_in = mask_ff | bit_sel;
                  CMD_CLR_REQ:      req_in = '0;
                  CMD_CLR_REQ_BIT:  req_in = req_ff & ~bit_sel;
                  CMD_SET_REQ:      req_in = ALL_ONES;
                  CMD_SET_REQ_BIT:  req_in = req_ff | bit_sel;
                  CMD_CLR_ISR:      isr_in = '0;
                  CMD_CLR_ISR_BIT:  isr_in = isr_ff & ~bit_sel;
                  CMD_MODE0_A, CMD_MODE0_B, CMD_MODE0_C, CMD_MODE0_D: begin
                     mode_in = (mode_ff & MODE_KEEP_HIGH) | (cmd.data[7:0] & MODE_LOW_FIELD);
                  end
                  CMD_MODE1_A, CMD_MODE1_B: begin
                     mode_in = (mode_ff & MODE_KEEP_RSEL)
                             | ({cmd.data[4:0], 3'b000} & MODE_RSEL_FIELD);
                     if (cmd.data[1:0] == MASTER_ON) begin
                        mode_in[MODE_MASTER_BIT] = 1'b1;
                     end else if (cmd.data[1:0] == MASTER_OFF) begin
                        mode_in[MODE_MASTER_BIT] = 1'b0;
                     end
                  end
                  CMD_PSEL_MASK_A, CMD_PSEL_MASK_B: wsel_in = WSEL_MASK;
                  CMD_PSEL_ACLR_A, CMD_PSEL_ACLR_B: wsel_in = WSEL_ACLR;
                  CMD_PSEL_VEC: begin
                     wsel_in = WSEL_VEC;
                     vsel_in = cmd.data[2:0];
                  end
                  default: ;
               endcase
            end
         end else begin
            unique case (wsel_ff)
               WSEL_MASK: mask_in = cmd.data[7:0];
               WSEL_ACLR: aclr_in = cmd.data[7:0];
               WSEL_VEC:  vec_in[vsel_ff] = cmd.data[VECTOR_WIDTH-1:0];
               default: ;
            endcase
         end
      end

      if (cmd.set_en) begin
         req_in = req_ff | cmd.rq;
      end

      if (cmd.ack_en) begin
         req_in = req_ff & ~ack_bit;
         if ((aclr_ff & ack_bit) == 8'd0) begin
            isr_in = isr_ff | ack_bit;
         end
         if (mode_ff[MODE_ROT_BIT]) begin
            rot_in = pend.line + 3'd1;
         end
      end

      pend_next = find_pending(req_in & ~mask_in, mode_in[MODE_ROT_BIT] ? rot_in : 3'd0);

      status = pend.found ? {5'd0, pend.line} : STATUS_NONE;
      status[3] = mode_ff[MODE_MASTER_BIT];
      status[4] = mode_ff[MODE_POLLED_BIT];
      status[5] = mode_ff[MODE_ROT_BIT];

      stat.qual      = pend.found && mode_ff[MODE_MASTER_BIT] && !mode_ff[MODE_POLLED_BIT];
      stat.qual_next = pend_next.found && mode_in[MODE_MASTER_BIT]
                    && !mode_in[MODE_POLLED_BIT];
      stat.vector    = 16'(mode_ff[MODE_COMMON_BIT] ? vec_ff[0] : vec_ff[pend.line]);
      if (cmd.port) begin
         stat.rd_data = status;
      end else begin
         case (mode_ff[6:5])
            RSEL_ISR:  stat.rd_data = isr_ff;
            RSEL_MASK: stat.rd_data = mask_ff;
            RSEL_REQ:  stat.rd_data = req_ff;
            RSEL_ACLR: stat.rd_data = aclr_ff;
            default:   stat.rd_data = aclr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff  <= '0;
         isr_ff  <= '0;
         mask_ff <= ALL_ONES;
         aclr_ff <= '0;
         mode_ff <= '0;
         rot_ff  <= '0;
         wsel_ff <= WSEL_MASK;
         vsel_ff <= '0;
         vec_ff  <= '{default: '0};
      end else begin
         req_ff  <= req_in;
         isr_ff  <= isr_in;
         mask_ff <= mask_in;
         aclr_ff <= aclr_in;
         mode_ff <= mode_in;
         rot_ff  <= rot_in;
         wsel_ff <= wsel_in;
         vsel_ff <= vsel_in;
         vec_ff  <= vec_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/triple_vectored_interrupt_controller.sv =====
// Top level of the triple vectored interrupt controller.
// The req_bus channel carries one transaction per item: a bus read or write of a
// controller's data or command/status port, a set of request lines, or a processor
// acknowledge. The rsp_bus channel returns one transaction for every request
// transaction: the read byte, the acknowledged vector, the no-interrupt flag and the
// group interrupt line as it stands after that request has taken effect.
// A request is captured in an input register; when the output register is free or is
// being emptied, the controllers update their state and the result is loaded into the
// output register, from which it is offered on rsp_bus. One request is taken every
// cycle when the receiver keeps rsp_bus.ready high.
// When the receiver stalls, the result is held in the output register while one more
// request may still be captured in the input register; req_bus.ready then drops
// until the output register is emptied.
// Synchronous reset empties both registers and returns every controller to its reset
// state: all masks set, all other registers and response vectors zero.
`default_nettype none

module triple_vectored_interrupt_controller
   import tvic_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   tvic_req_if.sink       req_bus,
   tvic_rsp_if.source     rsp_bus
);

   logic        in_valid_ff, in_valid_in;
   tvic_op_type op_ff;
   logic [1:0]  ctrl_ff;
   logic        port_ff;
   logic [15:0] data_ff;
   logic [7:0]  rq_ff;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  rd_ff, rd_in;
   logic [15:0] vec_ff, vec_in;
   logic        none_ff, none_in;
   logic        int_ff, int_in;

   logic        req_fire;
   logic        advance;
   logic        hit;
   logic [NUM_CONTROLLERS-1:0] grant;

   tvic_cmd_type  cmd  [NUM_CONTROLLERS];
   tvic_stat_type stat [NUM_CONTROLLERS];

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign in_valid_in   = req_fire || (in_valid_ff && !advance);
   assign out_valid_in  = advance || (out_valid_ff && !rsp_bus.ready);

   for (genvar c = 0; c < NUM_CONTROLLERS; c++) begin : gen_ctrl
      tvic_ctrl u_ctrl (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd[c]),
         .stat  (stat[c])
      );
   end

   always_comb begin
      hit    = 1'b0;
      grant  = '0;
      rd_in  = '0;
      vec_in = '0;
      int_in = 1'b0;
      for (int c = 0; c < NUM_CONTROLLERS; c++) begin
         if (stat[c].qual && !hit) begin
            grant[c] = 1'b1;
            hit      = 1'b1;
         end
      end
      for (int c = 0; c < NUM_CONTROLLERS; c++) begin
         cmd[c].wr_en  = advance && (op_ff == OP_WRITE) && (ctrl_ff == 2'(c));
         cmd[c].set_en = advance && (op_ff == OP_RAISE) && (ctrl_ff == 2'(c));
         cmd[c].ack_en = advance && (op_ff == OP_ACK) && grant[c];
         cmd[c].port   = port_ff;
         cmd[c].data   = data_ff;
         cmd[c].rq     = rq_ff;
         if ((op_ff == OP_READ) && (ctrl_ff == 2'(c))) begin
            rd_in = stat[c].rd_data;
         end
         if ((op_ff == OP_ACK) && grant[c]) begin
            vec_in = stat[c].vector;
         end
         int_in = int_in | stat[c].qual_next;
      end
      none_in = (op_ff == OP_ACK) && !hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= tvic_op_type'(req_bus.op);
         ctrl_ff <= req_bus.controller;
         port_ff <= req_bus.port_select;
         data_ff <= req_bus.write_data;
         rq_ff   <= req_bus.request_mask;
      end
      if (advance) begin
         rd_ff   <= rd_in;
         vec_ff  <= vec_in;
         none_ff <= none_in;
         int_ff  <= int_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.read_data    = rd_ff;
   assign rsp_bus.vector       = vec_ff;
   assign rsp_bus.no_interrupt = none_ff;
   assign rsp_bus.int_line     = int_ff;

`ifndef SYNTH
   a_grant_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(grant))
      else $error("More than one controller granted an acknowledge.");

   a_capture_moves: assert property (@(posedge clock) disable iff (reset)
      req_fire && in_valid_ff |-> advance)
      else $error("Request captured while the input register was held.");

   a_none_is_quiet: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && none_ff |-> (vec_ff == 16'd0) && (rd_ff == 8'd0))
      else $error("Empty acknowledge returned data.");

   a_ack_hit: assert property (@(posedge clock) disable iff (reset)
      advance && (op_ff == OP_ACK) && hit |=> out_valid_ff && !none_ff)
      else $error("Granted acknowledge reported no interrupt.");
`endif

endmodule

`default_nettype wire
